### hdl/blzw_pkg.sv
// Shared types and constants for the binary LZW bit decoder.
`default_nettype none
package blzw_pkg;

	localparam int BYTE_BITS   = 8;
	localparam int MAX_RESULTS = 64;
	localparam int RES_CNT_W   = 7;
	localparam int CFG_W       = 10;
	localparam logic [CFG_W-1:0] DICT_LIMIT_RESET = 10'd512;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LIT,
		S_ERR,
		S_WALK,
		S_WPUSH,
		S_POPRD,
		S_POPEM,
		S_EOS,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		K_NORMAL,
		K_SPECIAL,
		K_PARTIAL
	} kind_t;

	typedef struct packed {
		logic accept;
		logic emit_lit;
		logic emit_pop;
		logic push_err;
		logic walk_code;
		logic add_special;
		logic walk_rd;
		logic walk_push;
		logic walk_root;
		logic pop_rd;
		logic finish_normal;
		logic finish_special;
		logic clr_acc;
		logic stream_init;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic first_seen;
		logic full;
		logic code_lt;
		logic code_eq;
		logic room;
		logic walk_lt2;
		logic sp_zero;
		logic emit_ok;
		logic push_ok;
		logic eos;
		logic gathered_nz;
		logic hold_v;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### hdl/binary_lzw_bit_decoder_unit.sv
// Top level of the binary LZW bit decoder: controller, datapath and checks.
// Usage:
//  - Input channel (in_valid / in_stall) carries one compressed bit per transaction
//    together with end_of_stream, which closes the stream after that bit.
//  - Output channel (out_valid / out_stall) carries one result per transaction:
//    a packed byte (byte_valid) or an invalid-code flag (code_error); last_of_run
//    marks the final result caused by one input transaction.
//  - cfg_wen / cfg_wdata write dict_limit; write only while the block is idle.
//  - A complete code walks its prefix chain through the dictionary RAM, pushing
//    each pattern bit onto the pattern stack, then pops the stack to emit the
//    pattern's bits in order.
//  - One result at a time is held back until the next one (or the end of the
//    transaction) shows whether it is the last; it then moves to the output register.
//  - in_stall is high while an item is being worked on.
//  - A stalled receiver holds the output register; the block waits when both the
//    held result and the output register are occupied.
//  - Reset clears all control state and sets dict_limit to 512; the dictionary RAM
//    needs no clearing, as only written entries are read.
`default_nettype none
module binary_lzw_bit_decoder_unit
	import blzw_pkg::*;
#(
	parameter int DICT_ENTRIES = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             compressed_bit,
	input  wire logic             end_of_stream,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [BYTE_BITS-1:0]  out_byte,
	output logic                  byte_valid,
	output logic                  code_error,
	output logic                  last_of_run
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: owns the item flow, datapath does the storage and arithmetic
	blzw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.busy     (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	blzw_datapath #(
		.DICT_ENTRIES (DICT_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wen        (cfg_wen),
		.cfg_wdata      (cfg_wdata),
		.compressed_bit (compressed_bit),
		.end_of_stream  (end_of_stream),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.code_error     (code_error),
		.last_of_run    (last_of_run),
		.cmd            (cmd),
		.sts            (sts)
	);

`ifndef SYNTHESIS
	// error results carry no byte
	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && code_error |-> !byte_valid && (out_byte == '0))
		else $error("error result carries a byte");

	// every result is either a byte or an error
	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_valid != code_error))
		else $error("result neither byte nor error");

	// an accepted item keeps the input side busy next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");
`endif

endmodule
`default_nettype wire

### hdl/blzw_ctrl.sv
// Sequencing state machine for the binary LZW bit decoder.
`default_nettype none
module blzw_ctrl
	import blzw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      busy,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	kind_t  kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_NORMAL;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				if (!sts.first_seen) state_d = S_LIT;
				else if (!sts.full) state_d = S_EOS;
				else if (sts.code_lt) begin
					state_d = S_WALK;
					kind_d  = K_NORMAL;
				end else if (sts.code_eq && sts.room) begin
					state_d = S_WALK;
					kind_d  = K_SPECIAL;
				end else state_d = S_ERR;
			end
			S_LIT: if (sts.emit_ok) state_d = S_EOS;
			S_ERR: if (sts.push_ok) state_d = S_EOS;
			S_WALK: state_d = sts.walk_lt2 ? S_POPRD : S_WPUSH;
			S_WPUSH: state_d = S_WALK;
			S_POPRD: state_d = sts.sp_zero ? S_EOS : S_POPEM;
			S_POPEM: if (sts.emit_ok) state_d = S_POPRD;
			S_EOS: begin
				if (!sts.eos) state_d = S_DONE;
				else if (sts.first_seen && sts.gathered_nz) begin
					if (sts.code_lt) begin
						state_d = S_WALK;
						kind_d  = K_PARTIAL;
					end else state_d = S_ERR;
				end else state_d = S_DONE;
			end
			S_DONE: if (!sts.hold_v || sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_DECODE: begin
				if (sts.first_seen && sts.full) begin
					if (sts.code_lt) cmd.walk_code = 1'b1;
					else if (sts.code_eq && sts.room) begin
						cmd.walk_code   = 1'b1;
						cmd.add_special = 1'b1;
					end else cmd.clr_acc = 1'b1;
				end
			end
			S_LIT: cmd.emit_lit = sts.emit_ok;
			S_ERR: cmd.push_err = sts.push_ok;
			S_WALK: begin
				cmd.walk_root = sts.walk_lt2;
				cmd.walk_rd   = !sts.walk_lt2;
			end
			S_WPUSH: cmd.walk_push = 1'b1;
			S_POPRD: begin
				cmd.pop_rd         = !sts.sp_zero;
				cmd.finish_normal  = sts.sp_zero && (kind_q == K_NORMAL);
				cmd.finish_special = sts.sp_zero && (kind_q == K_SPECIAL);
			end
			S_POPEM: cmd.emit_pop = sts.emit_ok;
			S_EOS: begin
				if (sts.eos) begin
					if (sts.first_seen && sts.gathered_nz) begin
						cmd.walk_code = sts.code_lt;
						cmd.clr_acc   = !sts.code_lt;
					end else cmd.stream_init = 1'b1;
				end
			end
			S_DONE: cmd.flush = sts.hold_v && sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### hdl/blzw_datapath.sv
// Dictionary, pattern stack, code gathering and byte packing.
`default_nettype none
module blzw_datapath
	import blzw_pkg::*;
#(
	parameter int DICT_ENTRIES = 512
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             compressed_bit,
	input  wire logic             end_of_stream,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output logic [BYTE_BITS-1:0]  out_byte,
	output logic                  byte_valid,
	output logic                  code_error,
	output logic                  last_of_run,
	input  wire cmd_t             cmd,
	output sts_t                  sts
);

	localparam int IW  = $clog2(DICT_ENTRIES);
	localparam int NW  = IW + 1;
	localparam int CWW = $clog2(IW + 1);
	localparam int LW  = (NW > CFG_W) ? NW : CFG_W;
	localparam int DW  = IW + 1;

	logic [CFG_W-1:0] dict_limit_q;
	logic [NW-1:0]    nfi_q;
	logic [CWW-1:0]   cw_q, gath_q;
	logic [IW-1:0]    acc_q, prev_q, code_q, walk_q;
	logic             prev_first_q, root_q, first_seen_q;
	logic             bit_q, eos_q;
	logic [NW-1:0]    sp_q;
	logic [BYTE_BITS-1:0] pack_q;
	logic [2:0]       pack_cnt_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic             hold_v_q, hold_bv_q, hold_err_q;
	logic [BYTE_BITS-1:0] hold_byte_q;
	logic [DW-1:0]    rd_q;
	logic             sbit_q;

	logic [DW-1:0] dict_mem [DICT_ENTRIES];
	logic          stack_mem [DICT_ENTRIES];

	logic [LW-1:0] cfg_ext, lim;
	logic          room, complete, res_full, out_free, push_ok;
	logic          emit, ebit, do_push, add_normal, add_any;
	logic [NW-1:0] nfi_inc;
	logic [BYTE_BITS-1:0] res_byte, pack_nx;

	always_comb begin
		cfg_ext = LW'(dict_limit_q);
		if (cfg_ext < LW'(2)) lim = LW'(2);
		else if (cfg_ext > LW'(DICT_ENTRIES)) lim = LW'(DICT_ENTRIES);
		else lim = cfg_ext;
	end

	assign room     = LW'(nfi_q) < lim;
	assign complete = (pack_cnt_q == 3'(BYTE_BITS - 1));
	assign res_full = (res_cnt_q >= RES_CNT_W'(MAX_RESULTS));
	assign out_free = !out_valid || !out_stall;
	assign push_ok  = res_full || !hold_v_q || out_free;
	assign emit     = cmd.emit_lit || cmd.emit_pop;
	assign ebit     = cmd.emit_lit ? bit_q : sbit_q;
	assign pack_nx  = {pack_q[BYTE_BITS-2:0], ebit};
	assign do_push  = (emit && complete) || cmd.push_err;
	assign res_byte = cmd.push_err ? '0 : pack_nx;
	assign add_normal = cmd.finish_normal && room;
	assign add_any  = add_normal || cmd.add_special;
	assign nfi_inc  = nfi_q + NW'(1);

	always_comb begin
		sts.first_seen  = first_seen_q;
		sts.full        = (gath_q == cw_q);
		sts.code_lt     = NW'(acc_q) < nfi_q;
		sts.code_eq     = NW'(acc_q) == nfi_q;
		sts.room        = room;
		sts.walk_lt2    = (walk_q < IW'(2));
		sts.sp_zero     = (sp_q == '0);
		sts.emit_ok     = !complete || push_ok;
		sts.push_ok     = push_ok;
		sts.eos         = eos_q;
		sts.gathered_nz = (gath_q != '0);
		sts.hold_v      = hold_v_q;
		sts.out_free    = out_free;
	end

	// dictionary and stack storage
	always_ff @(posedge clk) begin
		if (add_any)
			dict_mem[nfi_q[IW-1:0]] <= {prev_q, add_normal ? root_q : prev_first_q};
		if (cmd.walk_rd) rd_q <= dict_mem[walk_q];
		if (cmd.walk_push || cmd.walk_root)
			stack_mem[sp_q[IW-1:0]] <= cmd.walk_root ? walk_q[0] : rd_q[0];
		if (cmd.pop_rd) sbit_q <= stack_mem[IW'(sp_q - NW'(1))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_limit_q <= DICT_LIMIT_RESET;
			nfi_q        <= NW'(2);
			cw_q         <= CWW'(2);
			gath_q       <= '0;
			acc_q        <= '0;
			prev_q       <= '0;
			prev_first_q <= 1'b0;
			first_seen_q <= 1'b0;
			pack_q       <= '0;
			pack_cnt_q   <= '0;
			res_cnt_q    <= '0;
			hold_v_q     <= 1'b0;
			out_valid    <= 1'b0;
			sp_q         <= '0;
			eos_q        <= 1'b0;
		end else begin
			if (cfg_wen) dict_limit_q <= cfg_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;

			if (cmd.accept) begin
				bit_q     <= compressed_bit;
				eos_q     <= end_of_stream;
				res_cnt_q <= '0;
				if (first_seen_q) begin
					acc_q  <= {acc_q[IW-2:0], compressed_bit};
					gath_q <= gath_q + CWW'(1);
				end
			end
			if (cmd.walk_code || cmd.clr_acc) begin
				acc_q  <= '0;
				gath_q <= '0;
			end
			if (cmd.walk_code) begin
				code_q <= acc_q;
				walk_q <= acc_q;
				sp_q   <= '0;
			end
			if (add_any) begin
				nfi_q <= nfi_inc;
				if ((LW'(nfi_inc) < lim) && (nfi_inc >= (NW'(1) << cw_q)))
					cw_q <= cw_q + CWW'(1);
			end
			if (cmd.walk_push) begin
				sp_q   <= sp_q + NW'(1);
				walk_q <= rd_q[DW-1:1];
			end
			if (cmd.walk_root) begin
				sp_q   <= sp_q + NW'(1);
				root_q <= walk_q[0];
			end
			if (cmd.pop_rd) sp_q <= sp_q - NW'(1);
			if (cmd.finish_normal) begin
				prev_q       <= code_q;
				prev_first_q <= root_q;
			end
			if (cmd.finish_special) prev_q <= code_q;
			if (cmd.emit_lit) begin
				prev_q       <= IW'(bit_q);
				prev_first_q <= bit_q;
				first_seen_q <= 1'b1;
			end
			if (emit) begin
				pack_q     <= complete ? '0 : pack_nx;
				pack_cnt_q <= complete ? '0 : pack_cnt_q + 3'(1);
			end
			if (do_push && !res_full) begin
				res_cnt_q   <= res_cnt_q + RES_CNT_W'(1);
				hold_v_q    <= 1'b1;
				hold_byte_q <= res_byte;
				hold_bv_q   <= !cmd.push_err;
				hold_err_q  <= cmd.push_err;
				if (hold_v_q) begin
					out_valid   <= 1'b1;
					out_byte    <= hold_byte_q;
					byte_valid  <= hold_bv_q;
					code_error  <= hold_err_q;
					last_of_run <= 1'b0;
				end
			end
			if (cmd.flush) begin
				hold_v_q    <= 1'b0;
				out_valid   <= 1'b1;
				out_byte    <= hold_byte_q;
				byte_valid  <= hold_bv_q;
				code_error  <= hold_err_q;
				last_of_run <= 1'b1;
			end
			if (cmd.stream_init) begin
				nfi_q        <= NW'(2);
				cw_q         <= CWW'(2);
				acc_q        <= '0;
				gath_q       <= '0;
				prev_q       <= '0;
				prev_first_q <= 1'b0;
				first_seen_q <= 1'b0;
				pack_q       <= '0;
				pack_cnt_q   <= '0;
			end
		end
	end

endmodule
`default_nettype wire

### verif/tb_binary_lzw_bit_decoder_unit.sv
// Self-checking testbench for the binary LZW bit decoder unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_binary_lzw_bit_decoder_unit;
	import blzw_pkg::*;

	localparam int DICT_N     = 512;
	localparam int MAX_CYCLES = 1000000;
	localparam int SETTLE     = 40;   // cycles of quiet that end a sync, as before a register write

	// Kinds of entry in the stimulus queue
	typedef enum logic [1:0] {
		OP_BIT,   // one compressed bit transaction
		OP_SYNC,  // hold the sender until every expected result has come
		OP_CFG    // write dict_limit
	} op_kind_t;

	typedef struct {
		op_kind_t         kind;
		logic             cb;
		logic             eos;
		logic [CFG_W-1:0] val;
	} stim_t;

	typedef struct {
		logic [BYTE_BITS-1:0] byte_v;
		logic                 valid;
		logic                 err;
		logic                 last;
	} decoded_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic compressed_bit = 1'b0;
	logic end_of_stream = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BYTE_BITS-1:0] out_byte;
	logic byte_valid;
	logic code_error;
	logic last_of_run;

	binary_lzw_bit_decoder_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.compressed_bit(compressed_bit), .end_of_stream(end_of_stream),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_byte(out_byte), .byte_valid(byte_valid),
		.code_error(code_error), .last_of_run(last_of_run)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	stim_t    pending_q[$];
	decoded_t decoded_q[$];   // bytes and error flags still owed by the block

	int unsigned n_bits_sent = 0;
	int unsigned n_results = 0;
	int unsigned n_err_results = 0;
	int unsigned n_streams = 0;
	int unsigned n_mismatch = 0;
	int unsigned cycles = 0;
	logic        in_fire = 1'b0;     // a bit transaction completed at the last rising edge
	logic        syncing = 1'b0;
	int unsigned settle_cnt = 0;
	int unsigned send_gap = 0;
	int unsigned stall_cnt = 0;
	int unsigned run_cnt = 0;
	logic        long_hold_done = 1'b0;

	// ---------------------------------------------------------------------
	// Decoder prediction: own copy of dictionary, code gathering and packing
	// ---------------------------------------------------------------------
	logic [8:0]       dec_prefix[DICT_N];
	logic             dec_tail[DICT_N];
	logic             dec_first[DICT_N];
	logic [CFG_W-1:0] dec_limit;
	int unsigned      dec_next, dec_width, dec_acc, dec_gathered, dec_prev;
	logic             dec_seen;
	logic [7:0]       dec_pack;
	int unsigned      dec_pack_cnt;
	int unsigned      dec_step_cnt;

	function automatic int unsigned bit_len(int unsigned v);
		int unsigned n;
		n = 0;
		while (v != 0) begin
			n++;
			v >>= 1;
		end
		return n;
	endfunction

	function automatic int unsigned clamped_limit(logic [CFG_W-1:0] lim);
		if (lim < 2)
			return 2;
		if (lim > DICT_N)
			return DICT_N;
		return lim;
	endfunction

	function automatic void owe_result(logic [7:0] b, logic v, logic e);
		decoded_t r;
		if (dec_step_cnt < MAX_RESULTS) begin
			r.byte_v = b;
			r.valid = v;
			r.err = e;
			r.last = 1'b0;
			decoded_q.push_back(r);
			dec_step_cnt++;
		end
	endfunction

	function automatic void pack_bit(logic b);
		dec_pack = {dec_pack[6:0], b};
		dec_pack_cnt++;
		if (dec_pack_cnt >= BYTE_BITS) begin
			owe_result(dec_pack, 1'b1, 1'b0);
			dec_pack = '0;
			dec_pack_cnt = 0;
		end
	endfunction

	// walk the prefix chain back to a literal, then unpack first bit first
	function automatic void unpack_pattern(int unsigned code);
		logic        stk[DICT_N];
		int unsigned depth;
		int unsigned e;
		depth = 0;
		e = code;
		while (depth < DICT_N) begin
			stk[depth] = dec_tail[e];
			depth++;
			if (e < 2)
				break;
			e = dec_prefix[e];
		end
		while (depth > 0) begin
			depth--;
			pack_bit(stk[depth]);
		end
	endfunction

	function automatic void grow_dict(logic tail);
		int unsigned n;
		int unsigned w;
		n = dec_next;
		if (n >= DICT_N)
			return;
		dec_prefix[n] = dec_prev[8:0];
		dec_tail[n] = tail;
		dec_first[n] = dec_first[dec_prev];
		dec_next = n + 1;
		if (dec_next < clamped_limit(dec_limit)) begin
			w = bit_len(dec_next);
			if (w > dec_width)
				dec_width = w;
		end
	endfunction

	function automatic void restart_stream();
		dec_prefix[0] = '0; dec_tail[0] = 1'b0; dec_first[0] = 1'b0;
		dec_prefix[1] = '0; dec_tail[1] = 1'b1; dec_first[1] = 1'b1;
		dec_next = 2;
		dec_width = 2;
		dec_acc = 0;
		dec_gathered = 0;
		dec_prev = 0;
		dec_seen = 1'b0;
		dec_pack = '0;
		dec_pack_cnt = 0;
	endfunction

	function automatic void decode_bit(logic cb, logic eos);
		int unsigned code;
		int unsigned lim;
		dec_step_cnt = 0;
		if (!dec_seen) begin
			pack_bit(cb);
			dec_prev = cb;
			dec_seen = 1'b1;
		end else begin
			dec_acc = ((dec_acc << 1) | cb) & 16'hFFFF;
			dec_gathered++;
			if (dec_gathered >= dec_width) begin
				code = dec_acc;
				lim = clamped_limit(dec_limit);
				dec_acc = 0;
				dec_gathered = 0;
				if (code < dec_next) begin
					unpack_pattern(code);
					if (dec_next < lim)
						grow_dict(dec_first[code]);
					dec_prev = code;
				end else if (code == dec_next && dec_next < lim) begin
					// code not yet in the dictionary: previous pattern plus its own first bit
					grow_dict(dec_first[dec_prev]);
					unpack_pattern(code);
					dec_prev = code;
				end else begin
					owe_result('0, 1'b0, 1'b1);
				end
			end
		end
		if (eos) begin
			// partial code at the end is taken as an index as it stands
			if (dec_seen && dec_gathered > 0) begin
				if (dec_acc < dec_next)
					unpack_pattern(dec_acc);
				else
					owe_result('0, 1'b0, 1'b1);
			end
			restart_stream();
		end
		if (dec_step_cnt > 0)
			decoded_q[decoded_q.size()-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------------
	logic [CFG_W-1:0] gen_limit;   // dict_limit as the stream generator sees it

	function automatic void add_bit(logic cb, logic eos);
		stim_t s;
		s.kind = OP_BIT;
		s.cb = cb;
		s.eos = eos;
		s.val = '0;
		pending_q.push_back(s);
	endfunction

	function automatic void add_cfg(logic [CFG_W-1:0] v);
		stim_t s;
		s.kind = OP_SYNC;
		s.cb = 1'b0;
		s.eos = 1'b0;
		s.val = '0;
		pending_q.push_back(s);
		s.kind = OP_CFG;
		s.val = v;
		pending_q.push_back(s);
		gen_limit = v;
	endfunction

	function automatic void add_sync();
		stim_t s;
		s.kind = OP_SYNC;
		s.cb = 1'b0;
		s.eos = 1'b0;
		s.val = '0;
		pending_q.push_back(s);
	endfunction

	// Well-formed stream: a literal, then ncodes codes that are all valid at the
	// width the decoder will expect, optionally closed by a partial code.
	function automatic int unsigned add_stream(int unsigned ncodes, logic partial);
		int unsigned nf, w, lim, code, top, nb, k;
		int i;
		nb = 0;
		nf = 2;
		w = 2;
		lim = clamped_limit(gen_limit);
		if (ncodes == 0 && !partial) begin
			add_bit(1'($urandom_range(0, 1)), 1'b1);
			return 1;
		end
		add_bit(1'($urandom_range(0, 1)), 1'b0);
		nb++;
		for (k = 0; k < ncodes; k++) begin
			top = (nf < lim) ? nf : nf - 1;
			// lean towards recent entries so that patterns get long
			if ($urandom_range(0, 1) && top > 4)
				code = $urandom_range(top - 4, top);
			else
				code = $urandom_range(0, top);
			for (i = w - 1; i >= 0; i--) begin
				add_bit(code[i], (k == ncodes - 1) && !partial && i == 0);
				nb++;
			end
			if (nf < lim) begin
				nf++;
				if (nf < lim && bit_len(nf) > w)
					w = bit_len(nf);
			end
		end
		if (partial) begin
			top = $urandom_range(1, w - 1);
			for (i = 0; i < top; i++) begin
				add_bit(1'($urandom_range(0, 1)), i == top - 1);
				nb++;
			end
		end
		return nb;
	endfunction

	// Noise: random bits closed by an end of stream
	function automatic int unsigned add_noise(int unsigned len);
		int unsigned k;
		for (k = 0; k < len; k++)
			add_bit(1'($urandom_range(0, 1)), k == len - 1);
		return len;
	endfunction

	// ---------------------------------------------------------------------
	// Rising edge: register writes, accepted bit transactions, result checks
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cfg_wen)
			dec_limit = cfg_wdata;
		in_fire <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			decode_bit(compressed_bit, end_of_stream);
			n_bits_sent++;
			if (end_of_stream)
				n_streams++;
		end
	end

	// Monitor: each result transaction against the oldest owed result
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (code_error)
				n_err_results++;
			if (decoded_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("ERROR: unexpected result byte=%02h bv=%0b err=%0b last=%0b",
						out_byte, byte_valid, code_error, last_of_run);
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.byte_v || byte_valid !== want.valid ||
						code_error !== want.err || last_of_run !== want.last) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"ERROR: result %0d: got byte=%02h bv=%0b err=%0b last=%0b,",
							" want byte=%02h bv=%0b err=%0b last=%0b"}, n_results,
							out_byte, byte_valid, code_error, last_of_run,
							want.byte_v, want.valid, want.err, want.last);
				end
			end
		end
		if (cycles > MAX_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Driver: falling edge, fed from pending_q
	// ---------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(negedge clk) begin
		logic  nxt_valid, nxt_wen;
		stim_t s;
		nxt_valid = in_valid;
		nxt_wen = 1'b0;
		if (arst_n && !(in_valid && !in_fire)) begin
			nxt_valid = 1'b0;
			if (syncing) begin
				// hold off until the block has drained and gone quiet
				if (decoded_q.size() == 0 && !in_stall && !out_valid) begin
					if (settle_cnt == 0)
						syncing <= 1'b0;
					else
						settle_cnt <= settle_cnt - 1;
				end else begin
					settle_cnt <= SETTLE;
				end
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending_q.size() > 0) begin
				s = pending_q.pop_front();
				case (s.kind)
					OP_BIT: begin
						nxt_valid = 1'b1;
						compressed_bit <= s.cb;
						end_of_stream <= s.eos;
						send_gap <= pick_gap();
					end
					OP_SYNC: begin
						syncing <= 1'b1;
						settle_cnt <= SETTLE;
					end
					OP_CFG: begin
						nxt_wen = 1'b1;
						cfg_wdata <= s.val;
					end
					default: ;
				endcase
			end
		end
		in_valid <= nxt_valid;
		cfg_wen <= nxt_wen;
	end

	// ---------------------------------------------------------------------
	// Receiver: random stalls, one long hold-off to back the block up
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		int unsigned r;
		if (!long_hold_done && n_bits_sent >= 120) begin
			long_hold_done <= 1'b1;
			stall_cnt <= 400;
			out_stall <= 1'b1;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_stall <= 1'b1;
		end else if (run_cnt > 0) begin
			run_cnt <= run_cnt - 1;
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			out_stall <= 1'b0;
			if (r < 15)
				run_cnt <= $urandom_range(10, 40);   // stretch with no stalls
			else if (r < 55)
				stall_cnt <= $urandom_range(1, 3);
			else if (r < 62)
				stall_cnt <= $urandom_range(10, 50);
		end
	end

	// ---------------------------------------------------------------------
	// Sequence: reset, directed streams, random streams, end of run
	// ---------------------------------------------------------------------
	initial begin
		int unsigned budget, sent;
		dec_limit = DICT_LIMIT_RESET;
		gen_limit = DICT_LIMIT_RESET;
		restart_stream();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// literal that ends the stream, both values
		add_bit(1'b0, 1'b1);
		add_bit(1'b1, 1'b1);
		// code above the next free index
		add_bit(1'b0, 1'b0); add_bit(1'b1, 1'b0); add_bit(1'b1, 1'b1);
		// code equal to the next free index, then a partial code at the end
		add_bit(1'b1, 1'b0); add_bit(1'b1, 1'b0); add_bit(1'b0, 1'b0); add_bit(1'b1, 1'b1);
		// partial code naming the literal index 1
		add_bit(1'b0, 1'b0); add_bit(1'b1, 1'b1);
		// special case while full: limit 3 lets only index 2 in
		add_cfg(10'd3);
		add_bit(1'b1, 1'b0); add_bit(1'b1, 1'b0); add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0); add_bit(1'b1, 1'b1);
		// limit below the literals clamps to 2: no entries ever added
		add_cfg(10'd0);
		add_bit(1'b0, 1'b0); add_bit(1'b1, 1'b0); add_bit(1'b0, 1'b1);
		// limit above the dictionary size clamps to it
		add_cfg(10'h3FF);
		void'(add_stream(4, 1'b1));

		budget = 150;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 9))
				0: add_cfg(CFG_W'($urandom_range(3, 40)));
				1: add_cfg(10'd512);
				2: add_cfg(CFG_W'($urandom_range(41, 512)));
				default: ;
			endcase
			if ($urandom_range(0, 9) < 2)
				sent += add_noise($urandom_range(1, 12));
			else
				sent += add_stream($urandom_range(0, 14), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0)
				add_sync();
		end
		// small dictionary filled right up, then codes while full
		add_cfg(10'd10);
		void'(add_stream(14, 1'b0));
		add_sync();

		wait (pending_q.size() == 0 && !syncing && !in_valid);
		repeat (200) @(posedge clk);

		$display("Ran %0d compressed bits in %0d streams; %0d results, %0d code errors.",
			n_bits_sent, n_streams, n_results, n_err_results);
		if (decoded_q.size() != 0) begin
			$display("ERROR: %0d expected results never came", decoded_q.size());
			n_mismatch++;
		end
		$display("Mismatches: %0d over %0d cycles", n_mismatch, cycles);
		if (n_mismatch == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
